// File: sv/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety allocator package
// Shared constants, command and register codes, config load struct.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int MAX_PROCESSES_DEF = 16;
   localparam int NUM_RESOURCES_DEF = 4;
   localparam int COUNT_WIDTH_DEF   = 16;

   localparam int FIELD_W = 16;   // width of pid, amounts and csr data
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] CMD_NEW       = 2'd0;
   localparam logic [1:0] CMD_REQUEST   = 2'd1;
   localparam logic [1:0] CMD_TERMINATE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPES_USED = 3'd4;

   localparam logic [2:0] TYPES_USED_RESET = 3'd4;

   // Config write as seen by the core (free pool reload)
   typedef struct packed {
      logic                 load;
      logic [CSR_IDX_W-1:0] index;
      logic [FIELD_W-1:0]   value;
   } cfg_load_type;

endpackage

// File: sv/bsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bsa_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety allocator core
// Command sequencer: owner scan, table row read-modify-write, safety passes.
// ----------------------------------------------------------------------------
module bsa_core #(
   parameter int MAX_PROCESSES = bsa_pkg::MAX_PROCESSES_DEF,
   parameter int NUM_RESOURCES = bsa_pkg::NUM_RESOURCES_DEF,
   parameter int COUNT_WIDTH   = bsa_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_valid,
   output logic                                                req_stall,
   input  logic [1:0]                                          req_command,
   input  logic [bsa_pkg::FIELD_W-1:0]                         req_process_id,
   input  logic [NUM_RESOURCES-1:0][bsa_pkg::FIELD_W-1:0]      req_amount,
   input  logic [2:0]                                          types_used,
   input  logic [NUM_RESOURCES-1:0][COUNT_WIDTH-1:0]           totals,
   input  bsa_pkg::cfg_load_type                               cfg,
   output logic                                                res_valid,
   output logic                                                res_granted,
   input  logic                                                res_take
);

   localparam int MP  = MAX_PROCESSES;
   localparam int NR  = NUM_RESOURCES;
   localparam int CW  = COUNT_WIDTH;
   localparam int IW  = (MP > 1) ? $clog2(MP) : 1;
   localparam int CNW = $clog2(MP + 1);
   localparam int AW  = (CW > bsa_pkg::FIELD_W) ? CW : bsa_pkg::FIELD_W;
   localparam int SW  = AW + $clog2(MP + 1) + 1;
   localparam int RW  = 3 * NR * CW;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_ROW, S_CHECK, S_SAFE, S_EVAL, S_DONE
   } state_type;

   typedef logic [NR-1:0][CW-1:0] vec_type;

   state_type                          state_ff;
   logic [1:0]                         cmd_ff;
   logic [bsa_pkg::FIELD_W-1:0]        pid_ff;
   logic [NR-1:0][bsa_pkg::FIELD_W-1:0] amt_ff;
   logic [MP-1:0]                      valid_ff;
   logic [MP-1:0]                      fin_ff;
   vec_type                            free_ff;
   logic [NR-1:0][SW-1:0]              work_ff;
   logic [CNW-1:0]                     cnt_ff;
   logic [CNW-1:0]                     pass_ff;
   logic                               pend_ff;
   logic [IW-1:0]                      pend_slot_ff;
   logic                               found_ff;
   logic [IW-1:0]                      who_ff;
   logic                               hole_ff;
   logic [IW-1:0]                      hole_slot_ff;
   logic                               progress_ff;
   logic [RW-1:0]                      who_row_ff;
   logic                               granted_ff;

   // memories
   logic [bsa_pkg::FIELD_W-1:0] own_rd_data;
   logic                        own_we;
   logic [RW-1:0]               tab_rd_data;
   logic [IW-1:0]               tab_rd_addr;
   logic                        tab_we;
   logic [IW-1:0]               tab_wr_addr;
   logic [RW-1:0]               tab_wr_data;

   vec_type rd_claim, rd_held, rd_need, who_held, who_need;
   vec_type new_vec, cm_held, cm_need, free_sub, free_sat;
   logic [NR-1:0][SW-1:0] work_init, work_add;
   logic over_total, req_bad, fits, safe_all, is_who, new_ok;
   logic [AW:0] lhs, rhs;
   logic [SW-1:0] need_adj;
   logic [CW:0] sat_sum;

   bsa_ram #(.WIDTH(bsa_pkg::FIELD_W), .DEPTH(MP)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (hole_slot_ff),
      .wr_data (pid_ff),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (own_rd_data)
   );

   bsa_ram #(.WIDTH(RW), .DEPTH(MP)) u_table_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_data),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   // row layout: {need, held, claim}
   assign rd_claim = tab_rd_data[NR*CW-1:0];
   assign rd_held  = tab_rd_data[2*NR*CW-1:NR*CW];
   assign rd_need  = tab_rd_data[3*NR*CW-1:2*NR*CW];
   assign who_held = who_row_ff[2*NR*CW-1:NR*CW];
   assign who_need = who_row_ff[3*NR*CW-1:2*NR*CW];

   assign tab_rd_addr = (state_ff == S_SAFE) ? cnt_ff[IW-1:0] : who_ff;
   assign is_who      = (pend_slot_ff == who_ff);
   assign safe_all    = ~|(valid_ff & ~fin_ff);
   assign new_ok      = !found_ff && !over_total && hole_ff;

   always_comb begin
      over_total = 1'b0;
      req_bad    = 1'b0;
      fits       = 1'b1;
      lhs        = '0;
      rhs        = '0;
      need_adj   = '0;
      sat_sum    = '0;
      for (int t = 0; t < NR; t++) begin
         new_vec[t]   = (t < int'(types_used)) ? CW'(amt_ff[t]) : '0;
         cm_held[t]   = who_held[t];
         cm_need[t]   = who_need[t];
         free_sub[t]  = free_ff[t];
         work_init[t] = SW'(free_ff[t]) - SW'(amt_ff[t]);
         work_add[t]  = work_ff[t] + SW'(rd_held[t]) + (is_who ? SW'(amt_ff[t]) : '0);
         sat_sum      = (CW + 1)'(free_ff[t]) + (CW + 1)'(rd_held[t]);
         free_sat[t]  = sat_sum[CW] ? {CW{1'b1}} : sat_sum[CW-1:0];
         if (t < int'(types_used)) begin
            cm_held[t]  = who_held[t] + CW'(amt_ff[t]);
            cm_need[t]  = who_need[t] - CW'(amt_ff[t]);
            free_sub[t] = free_ff[t] - CW'(amt_ff[t]);
            if (AW'(amt_ff[t]) > AW'(totals[t])) begin
               over_total = 1'b1;
            end
            lhs = (AW + 1)'(rd_claim[t]);
            rhs = (AW + 1)'(amt_ff[t]) + (AW + 1)'(rd_held[t]);
            if (lhs < rhs || AW'(amt_ff[t]) > AW'(free_ff[t])) begin
               req_bad = 1'b1;
            end
            need_adj = SW'(rd_need[t]) - (is_who ? SW'(amt_ff[t]) : '0);
            if (need_adj > work_ff[t]) begin
               fits = 1'b0;
            end
         end
      end
   end

   always_comb begin
      own_we      = (state_ff == S_DECIDE) && (cmd_ff == bsa_pkg::CMD_NEW) && new_ok;
      tab_we      = own_we;
      tab_wr_addr = hole_slot_ff;
      tab_wr_data = {new_vec, vec_type'('0), new_vec};
      if (state_ff == S_EVAL) begin
         tab_we      = safe_all;
         tab_wr_addr = who_ff;
         tab_wr_data = {cm_need, cm_held, who_row_ff[NR*CW-1:0]};
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign res_valid   = (state_ff == S_DONE);
   assign res_granted = granted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         fin_ff      <= '0;
         free_ff     <= '0;
         pend_ff     <= 1'b0;
         granted_ff  <= 1'b0;
      end else begin
         // config reload of the free pool (block idle)
         for (int t = 0; t < NR; t++) begin
            if (cfg.load && cfg.index == bsa_pkg::CSR_TOTAL_0 + 3'(t)) begin
               free_ff[t] <= CW'(AW'(cfg.value));
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  pid_ff   <= req_process_id;
                  amt_ff   <= req_amount;
                  cnt_ff   <= '0;
                  pend_ff  <= 1'b0;
                  found_ff <= 1'b0;
                  hole_ff  <= 1'b0;
                  if (req_command == bsa_pkg::CMD_NEW || req_command == bsa_pkg::CMD_REQUEST
                      || req_command == bsa_pkg::CMD_TERMINATE) begin
                     state_ff <= S_SCAN;
                  end else begin
                     granted_ff <= 1'b0;
                     state_ff   <= S_DONE;
                  end
               end
            end
            S_SCAN: begin
               pend_ff      <= (cnt_ff != CNW'(MP));
               pend_slot_ff <= cnt_ff[IW-1:0];
               if (cnt_ff != CNW'(MP)) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (pend_ff) begin
                  if (valid_ff[pend_slot_ff] && own_rd_data == pid_ff && !found_ff) begin
                     found_ff <= 1'b1;
                     who_ff   <= pend_slot_ff;
                  end
                  if (!valid_ff[pend_slot_ff] && !hole_ff) begin
                     hole_ff      <= 1'b1;
                     hole_slot_ff <= pend_slot_ff;
                  end
               end else if (cnt_ff == CNW'(MP)) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (cmd_ff == bsa_pkg::CMD_NEW) begin
                  granted_ff <= new_ok;
                  if (new_ok) begin
                     valid_ff[hole_slot_ff] <= 1'b1;
                  end
                  state_ff <= S_DONE;
               end else if (!found_ff) begin
                  granted_ff <= 1'b0;
                  state_ff   <= S_DONE;
               end else begin
                  state_ff <= S_ROW;
               end
            end
            S_ROW: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               who_row_ff <= tab_rd_data;
               if (cmd_ff == bsa_pkg::CMD_TERMINATE) begin
                  free_ff          <= free_sat;
                  valid_ff[who_ff] <= 1'b0;
                  granted_ff       <= 1'b1;
                  state_ff         <= S_DONE;
               end else if (req_bad) begin
                  granted_ff <= 1'b0;
                  state_ff   <= S_DONE;
               end else begin
                  work_ff     <= work_init;
                  fin_ff      <= '0;
                  pass_ff     <= '0;
                  cnt_ff      <= '0;
                  pend_ff     <= 1'b0;
                  progress_ff <= 1'b0;
                  state_ff    <= S_SAFE;
               end
            end
            S_SAFE: begin
               pend_ff      <= (cnt_ff != CNW'(MP));
               pend_slot_ff <= cnt_ff[IW-1:0];
               if (cnt_ff != CNW'(MP)) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (pend_ff) begin
                  if (valid_ff[pend_slot_ff] && !fin_ff[pend_slot_ff] && fits) begin
                     for (int t = 0; t < NR; t++) begin
                        if (t < int'(types_used)) begin
                           work_ff[t] <= work_add[t];
                        end
                     end
                     fin_ff[pend_slot_ff] <= 1'b1;
                     progress_ff          <= 1'b1;
                  end
               end else if (cnt_ff == CNW'(MP)) begin
                  // end of a pass
                  if (!progress_ff || pass_ff == CNW'(MP - 1)) begin
                     state_ff <= S_EVAL;
                  end else begin
                     pass_ff     <= pass_ff + 1'b1;
                     cnt_ff      <= '0;
                     progress_ff <= 1'b0;
                  end
               end
            end
            S_EVAL: begin
               granted_ff <= safe_all;
               if (safe_all) begin
                  free_ff <= free_sub;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (res_take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: sv/bankers_safety_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety allocator unit
// Operation: new runs an owner RAM scan, terminate the scan plus a row read;
// a request adds to the terminate work up to MAX_PROCESSES safety passes
// over the table RAM, one row per cycle, all types in parallel.
// Throughput: one item at a time; next item taken once the result is in
// the output register. An unused command code is refused without a scan.
// Reset: clears slot valid bits, free pool, totals; types used resets to 4.
// ----------------------------------------------------------------------------
module bankers_safety_allocator_unit #(
   parameter int MAX_PROCESSES = bsa_pkg::MAX_PROCESSES_DEF,
   parameter int NUM_RESOURCES = bsa_pkg::NUM_RESOURCES_DEF,
   parameter int COUNT_WIDTH   = bsa_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // item input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic [bsa_pkg::FIELD_W-1:0]   req_process_id,
   input  logic [bsa_pkg::FIELD_W-1:0]   req_amount_0,
   input  logic [bsa_pkg::FIELD_W-1:0]   req_amount_1,
   input  logic [bsa_pkg::FIELD_W-1:0]   req_amount_2,
   input  logic [bsa_pkg::FIELD_W-1:0]   req_amount_3,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_granted,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsa_pkg::FIELD_W-1:0]   csr_data
);

   localparam int NR = NUM_RESOURCES;
   localparam int CW = COUNT_WIDTH;
   localparam int AW = (CW > bsa_pkg::FIELD_W) ? CW : bsa_pkg::FIELD_W;

   logic [3:0][bsa_pkg::FIELD_W-1:0]   amt_all;
   logic [NR-1:0][CW-1:0]              totals_ff;
   logic [2:0]                         types_used_ff;
   logic [2:0]                         types_used;
   bsa_pkg::cfg_load_type              cfg;
   logic                               csr_write;
   logic                               res_valid;
   logic                               res_granted;
   logic                               res_take;
   logic                               rsp_valid_ff;
   logic                               rsp_granted_ff;

   assign amt_all = {req_amount_3, req_amount_2, req_amount_1, req_amount_0};

   // Config registers: always writable; the block is idle by contract.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cfg       = '{load: csr_write, index: csr_index, value: csr_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         totals_ff     <= '0;
         types_used_ff <= bsa_pkg::TYPES_USED_RESET;
      end else if (csr_write) begin
         // totals are kept to COUNT_WIDTH bits
         for (int t = 0; t < NR; t++) begin
            if (csr_index == bsa_pkg::CSR_TOTAL_0 + 3'(t)) begin
               totals_ff[t] <= CW'(AW'(csr_data));
            end
         end
         if (csr_index == bsa_pkg::CSR_TYPES_USED) begin
            types_used_ff <= csr_data[2:0];
         end
      end
   end

   // types beyond the built-in count are ignored
   assign types_used = (types_used_ff > 3'(NR)) ? 3'(NR) : types_used_ff;

   bsa_core #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .NUM_RESOURCES (NUM_RESOURCES),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_process_id (req_process_id),
      .req_amount     (amt_all[NR-1:0]),
      .types_used     (types_used),
      .totals         (totals_ff),
      .cfg            (cfg),
      .res_valid      (res_valid),
      .res_granted    (res_granted),
      .res_take       (res_take)
   );

   // Output register: frees the core while the result waits downstream.
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_take) begin
         rsp_valid_ff   <= 1'b1;
         rsp_granted_ff <= res_granted;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;

endmodule

// File: tb/sv/tb_bankers_safety_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety allocator unit testbench
// Drives new/request/terminate commands under several total and types-used
// settings, predicts each grant with an independent model of the process
// table and the safety check, and compares every result in order.
// ----------------------------------------------------------------------------

// Predicts grant decisions and holds the grants still due from the block.
class bsa_scoreboard;
   localparam int SLOTS = bsa_pkg::MAX_PROCESSES_DEF;
   localparam int TYPES = bsa_pkg::NUM_RESOURCES_DEF;
   localparam longint unsigned CNT_MAX = 64'hFFFF;

   bit [15:0]       totals[TYPES];
   bit [2:0]        types_reg;
   bit              live[SLOTS];
   bit [15:0]       owner[SLOTS];
   longint unsigned claim[SLOTS][TYPES];
   longint unsigned held[SLOTS][TYPES];
   longint unsigned need[SLOTS][TYPES];
   longint unsigned free_cnt[TYPES];
   bit              grant_q[$];
   int              errors;

   function new();
      types_reg = bsa_pkg::TYPES_USED_RESET;
      errors = 0;
      for (int t = 0; t < TYPES; t++) begin
         totals[t] = 0;
         free_cnt[t] = 0;
      end
      for (int s = 0; s < SLOTS; s++) live[s] = 0;
   endfunction

   function void write_reg(bit [2:0] idx, bit [15:0] data);
      if (idx < bsa_pkg::CSR_TYPES_USED) begin
         totals[idx] = data;
         free_cnt[idx] = data;
      end else if (idx == bsa_pkg::CSR_TYPES_USED) begin
         types_reg = data[2:0];
      end
   endfunction

   function int active_types();
      return (types_reg > TYPES) ? TYPES : int'(types_reg);
   endfunction

   function int slot_of(bit [15:0] pid);
      for (int s = 0; s < SLOTS; s++)
         if (live[s] && owner[s] == pid) return s;
      return -1;
   endfunction

   // Safety check with rq tentatively granted to slot who
   function bit is_safe(int who, longint unsigned rq[TYPES], int nt);
      longint unsigned work[TYPES];
      longint unsigned nd;
      bit done[SLOTS];
      bit moved;
      bit fits;
      for (int t = 0; t < nt; t++) work[t] = free_cnt[t] - rq[t];
      for (int s = 0; s < SLOTS; s++) done[s] = 0;
      for (int p = 0; p < SLOTS; p++) begin
         moved = 0;
         for (int s = 0; s < SLOTS; s++) begin
            if (!live[s] || done[s]) continue;
            fits = 1;
            for (int t = 0; t < nt; t++) begin
               nd = need[s][t] - ((s == who) ? rq[t] : 0);
               if (nd > work[t]) fits = 0;
            end
            if (fits) begin
               moved = 1;
               for (int t = 0; t < nt; t++)
                  work[t] += held[s][t] + ((s == who) ? rq[t] : 0);
               done[s] = 1;
            end
         end
         if (!moved) break;
      end
      for (int s = 0; s < SLOTS; s++)
         if (live[s] && !done[s]) return 0;
      return 1;
   endfunction

   function void note_item(bit [1:0] cmd, bit [15:0] pid, bit [15:0] amt[TYPES]);
      longint unsigned rq[TYPES];
      longint unsigned v;
      int nt;
      int s;
      bit ok;
      nt = active_types();
      s = slot_of(pid);
      for (int t = 0; t < TYPES; t++) rq[t] = amt[t];
      ok = 0;
      case (cmd)
         bsa_pkg::CMD_NEW: begin
            ok = (s < 0);
            for (int t = 0; t < nt; t++)
               if (rq[t] > totals[t]) ok = 0;
            if (ok) begin
               s = -1;
               for (int k = SLOTS - 1; k >= 0; k--)
                  if (!live[k]) s = k;
               ok = (s >= 0);
            end
            if (ok) begin
               live[s] = 1;
               owner[s] = pid;
               for (int t = 0; t < TYPES; t++) begin
                  claim[s][t] = (t < nt) ? rq[t] : 0;
                  need[s][t] = claim[s][t];
                  held[s][t] = 0;
               end
            end
         end
         bsa_pkg::CMD_REQUEST: begin
            ok = (s >= 0);
            if (ok)
               for (int t = 0; t < nt; t++)
                  if (claim[s][t] < rq[t] + held[s][t] || rq[t] > free_cnt[t]) ok = 0;
            if (ok) ok = is_safe(s, rq, nt);
            if (ok)
               for (int t = 0; t < nt; t++) begin
                  free_cnt[t] -= rq[t];
                  held[s][t] += rq[t];
                  need[s][t] -= rq[t];
               end
         end
         bsa_pkg::CMD_TERMINATE: begin
            ok = (s >= 0);
            if (ok) begin
               for (int t = 0; t < TYPES; t++) begin
                  v = free_cnt[t] + held[s][t];
                  free_cnt[t] = (v > CNT_MAX) ? CNT_MAX : v;
               end
               live[s] = 0;
            end
         end
         default: ok = 0;
      endcase
      grant_q = {grant_q, ok};
   endfunction

   function void check_grant(bit granted);
      bit want;
      if (grant_q.size() == 0) begin
         $display("%0t: unexpected result, expected none actual granted=%0d",
                  $time, granted);
         errors++;
         return;
      end
      want = grant_q.pop_front();
      if (want != granted) begin
         $display("%0t: granted mismatch, expected %0d actual %0d", $time, want, granted);
         errors++;
      end
   endfunction
endclass

module tb_bankers_safety_allocator_unit;
   localparam logic [1:0] CMD_UNUSED = 2'd3;     // no operation behind this code
   localparam logic [2:0] CSR_SPARE  = 3'd7;     // unmapped register index
   localparam int NTYPES = bsa_pkg::NUM_RESOURCES_DEF;

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          req_valid = 0;
   logic                          req_stall;
   logic [1:0]                    req_command = bsa_pkg::CMD_NEW;
   logic [bsa_pkg::FIELD_W-1:0]   req_process_id = 0;
   logic [bsa_pkg::FIELD_W-1:0]   req_amount_0 = 0;
   logic [bsa_pkg::FIELD_W-1:0]   req_amount_1 = 0;
   logic [bsa_pkg::FIELD_W-1:0]   req_amount_2 = 0;
   logic [bsa_pkg::FIELD_W-1:0]   req_amount_3 = 0;
   logic                          rsp_valid;
   logic                          rsp_stall = 0;
   logic                          rsp_granted;
   logic                          csr_valid = 0;
   logic                          csr_ready;
   logic [bsa_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [bsa_pkg::FIELD_W-1:0]   csr_data = 0;

   bsa_scoreboard ledger = new();
   bit            quiet = 0;       // no idling on either side when set
   int            stall_left = 0;
   bit [15:0]     pid_pool[24];

   bankers_safety_allocator_unit dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Hard stop; slowest legal run is well under this.
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // Result side: random stall bursts
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result monitor
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) ledger.check_grant(rsp_granted);

   // All tasks are entered at a falling edge and return at one.
   task automatic csr_write(logic [2:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      ledger.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_item(logic [1:0] cmd, logic [15:0] pid, bit [15:0] amt[NTYPES]);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_process_id <= pid;
      req_amount_0   <= amt[0];
      req_amount_1   <= amt[1];
      req_amount_2   <= amt[2];
      req_amount_3   <= amt[3];
      do @(posedge clock); while (req_stall);
      ledger.note_item(cmd, pid, amt);
      @(negedge clock);
   endtask

   task automatic send4(logic [1:0] cmd, logic [15:0] pid,
                        int a0, int a1, int a2, int a3);
      bit [15:0] amt[NTYPES];
      amt[0] = 16'(a0); amt[1] = 16'(a1); amt[2] = 16'(a2); amt[3] = 16'(a3);
      send_item(cmd, pid, amt);
   endtask

   // Lower valid, then wait until every grant is back. Config is only
   // written from here, and every item answers, so no extra wait is needed.
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.grant_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_totals(int t0, int t1, int t2, int t3, logic [15:0] types);
      csr_write(bsa_pkg::CSR_TOTAL_0 + 3'd0, 16'(t0));
      csr_write(bsa_pkg::CSR_TOTAL_0 + 3'd1, 16'(t1));
      csr_write(bsa_pkg::CSR_TOTAL_0 + 3'd2, 16'(t2));
      csr_write(bsa_pkg::CSR_TOTAL_0 + 3'd3, 16'(t3));
      csr_write(bsa_pkg::CSR_TYPES_USED, types);
   endtask

   // Mostly new/request/terminate on a small set of ids with amounts
   // scaled to the totals, so requests get through the claim and pool checks.
   task automatic run_random(int count);
      bit [15:0] amt[NTYPES];
      logic [1:0] cmd;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         cmd = (pick < 25) ? bsa_pkg::CMD_NEW : (pick < 75) ? bsa_pkg::CMD_REQUEST :
               (pick < 96) ? bsa_pkg::CMD_TERMINATE : CMD_UNUSED;
         for (int t = 0; t < NTYPES; t++) begin
            if ($urandom_range(0, 9) == 0)
               amt[t] = 16'($urandom_range(0, 65535));
            else if (cmd == bsa_pkg::CMD_NEW)
               amt[t] = 16'($urandom_range(0, ledger.totals[t] + 1));
            else
               amt[t] = 16'($urandom_range(0, ledger.totals[t] / 3 + 1));
         end
         send_item(cmd, pid_pool[$urandom_range(0, 23)], amt);
      end
   endtask

   initial begin
      for (int i = 0; i < 20; i++) pid_pool[i] = 16'(i);
      pid_pool[20] = 16'hFFFF;
      pid_pool[21] = 16'h8000;
      pid_pool[22] = 16'($urandom_range(0, 65535));
      pid_pool[23] = 16'($urandom_range(0, 65535));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      @(negedge clock);

      // Phase 1: small totals, all four types, directed cases first
      set_totals(12, 9, 7, 5, 4);
      send4(bsa_pkg::CMD_NEW, 16'd1, 12, 9, 7, 5);
      send4(bsa_pkg::CMD_NEW, 16'd1, 1, 1, 1, 1);          // duplicate id
      send4(bsa_pkg::CMD_NEW, 16'd2, 13, 0, 0, 0);         // claim above total
      send4(bsa_pkg::CMD_REQUEST, 16'd9, 1, 0, 0, 0);      // unknown process
      send4(bsa_pkg::CMD_REQUEST, 16'd1, 6, 4, 3, 2);
      send4(bsa_pkg::CMD_NEW, 16'd2, 8, 8, 6, 4);
      send4(bsa_pkg::CMD_REQUEST, 16'd2, 6, 5, 4, 3);      // would leave state unsafe
      send4(bsa_pkg::CMD_REQUEST, 16'd1, 7, 0, 0, 0);      // beyond claim
      send4(bsa_pkg::CMD_REQUEST, 16'd2, 0, 0, 0, 0);
      send4(bsa_pkg::CMD_TERMINATE, 16'd9, 0, 0, 0, 0);    // unknown process
      send4(bsa_pkg::CMD_TERMINATE, 16'd1, 0, 0, 0, 0);
      send4(CMD_UNUSED, 16'd2, 65535, 65535, 65535, 65535);
      for (int k = 0; k < 16; k++)                // fill the table, then one more
         send4(bsa_pkg::CMD_NEW, pid_pool[k + 4], 1, 1, 1, 1);
      run_random(240);
      drain();                                    // sender waits for all grants
      run_random(240);
      drain();

      // Phase 2: full-scale totals; types value above 4 acts as 4
      set_totals(65535, 65535, 65535, 65535, 16'hFFFF);
      csr_write(CSR_SPARE, 16'h5A5A);
      run_random(450);
      drain();

      // Phase 3: two types, an empty third type
      set_totals(40, 30, 0, 1, 2);
      run_random(350);
      drain();

      // Phase 4: no type compared, every limit passes
      set_totals(0, 0, 0, 0, 0);
      run_random(150);
      drain();

      // Phase 5: three types, no idling on either side
      set_totals(20, 20, 20, 20, 3);
      quiet = 1;
      run_random(400);
      drain();

      repeat (300) @(posedge clock);
      if (ledger.grant_q.size() != 0)
         $display("%0t: %0d grants never arrived, expected 0 pending actual %0d",
                  $time, ledger.grant_q.size(), ledger.grant_q.size());
      if (ledger.errors == 0 && ledger.grant_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
